FILE: rtl/core/hf_pkg.sv
// ----------------------------------------------------------------------------
// hf_pkg
// shared types and constants of the tree-walk bit decoder
// ----------------------------------------------------------------------------
package hf_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int NODE_SLOTS_DEF = 512;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHILD
  } st_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // request from the walk controller to the node table
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_node;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
  } mem_req_t;

  // registered read data, slots beyond the table read as zero
  typedef struct packed {
    node_t node_a;
    node_t node_b;
  } mem_rsp_t;

endpackage

FILE: rtl/core/hf_if.sv
// ----------------------------------------------------------------------------
// hf_in_if / hf_out_if
// valid/ready channels of the tree-walk bit decoder
// ----------------------------------------------------------------------------
interface hf_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic                    bit_value;
  logic [hf_pkg::IDX_W-1:0] node_index;
  logic                    node_is_leaf;
  logic [hf_pkg::SYM_W-1:0] node_symbol;
  logic [hf_pkg::IDX_W-1:0] left_child;
  logic [hf_pkg::IDX_W-1:0] right_child;

  modport source (
    output valid, operation, bit_value, node_index, node_is_leaf, node_symbol,
           left_child, right_child,
    input  ready
  );
  modport sink (
    input  valid, operation, bit_value, node_index, node_is_leaf, node_symbol,
           left_child, right_child,
    output ready
  );
endinterface

interface hf_out_if;
  logic                    valid;
  logic                    ready;
  logic [hf_pkg::SYM_W-1:0] symbol;

  modport source (output valid, symbol, input ready);
  modport sink (input valid, symbol, output ready);
endinterface

FILE: rtl/core/hf_node_mem.sv
// ----------------------------------------------------------------------------
// hf_node_mem
// node table: one write port, two registered read ports
// ----------------------------------------------------------------------------
module hf_node_mem #(
  parameter int NODE_SLOTS = hf_pkg::NODE_SLOTS_DEF
) (
  input  logic             clk,
  input  hf_pkg::mem_req_t req,
  output hf_pkg::mem_rsp_t rsp
);

  localparam int AW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam logic [hf_pkg::IDX_W:0] SLOTS = (hf_pkg::IDX_W+1)'(NODE_SLOTS);

  hf_pkg::node_t mem [NODE_SLOTS];
  hf_pkg::node_t rd_a_r;
  hf_pkg::node_t rd_b_r;
  logic          ok_a_r;
  logic          ok_b_r;
  logic          wr_ok;
  logic          ok_a;
  logic          ok_b;

  assign wr_ok = ({1'b0, req.wr_addr} < SLOTS);
  assign ok_a  = ({1'b0, req.rd_addr_a} < SLOTS);
  assign ok_b  = ({1'b0, req.rd_addr_b} < SLOTS);

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_ok) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a_r <= mem[req.rd_addr_a[AW-1:0]];
      rd_b_r <= mem[req.rd_addr_b[AW-1:0]];
      ok_a_r <= ok_a;
      ok_b_r <= ok_b;
    end
  end

  // out-of-range slots read as an internal node with both children zero
  assign rsp.node_a = ok_a_r ? rd_a_r : '0;
  assign rsp.node_b = ok_b_r ? rd_b_r : '0;

endmodule

FILE: rtl/core/hf_walk_ctrl.sv
// ----------------------------------------------------------------------------
// hf_walk_ctrl
// walk sequencer: root and pointer registers, table access, result register
// ----------------------------------------------------------------------------
module hf_walk_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  hf_in_if.sink                    in_ch,
  hf_out_if.source                 out_ch,
  input  logic                     cfg_wr_en,
  input  logic [hf_pkg::IDX_W-1:0] cfg_wr_data,
  output hf_pkg::mem_req_t         req,
  input  hf_pkg::mem_rsp_t         rsp
);

  hf_pkg::st_t              state_r, state_nxt;
  logic [hf_pkg::IDX_W-1:0] root_r;
  logic [hf_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic [hf_pkg::IDX_W-1:0] child_r;
  logic                     bit_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [hf_pkg::SYM_W-1:0] out_sym_r;

  hf_pkg::op_t              op;
  logic                     in_acc;
  logic                     out_free;
  logic [hf_pkg::IDX_W-1:0] child_idx;
  logic                     emit;
  logic [hf_pkg::SYM_W-1:0] emit_sym;

  assign op        = hf_pkg::op_t'(in_ch.operation);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign child_idx = bit_r ? rsp.node_b.right : rsp.node_b.left;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hf_pkg::ST_IDLE: begin
        if (in_acc && op == hf_pkg::OP_DECODE) state_nxt = hf_pkg::ST_LOOK;
      end
      hf_pkg::ST_LOOK: begin
        if (!rsp.node_a.leaf) state_nxt = hf_pkg::ST_CHILD;
        else if (out_free)    state_nxt = hf_pkg::ST_IDLE;
      end
      hf_pkg::ST_CHILD: begin
        if (!rsp.node_b.leaf || out_free) state_nxt = hf_pkg::ST_IDLE;
      end
      default: state_nxt = hf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready       = 1'b0;
    req.wr_en         = 1'b0;
    req.wr_addr       = in_ch.node_index;
    req.wr_node.leaf   = in_ch.node_is_leaf;
    req.wr_node.symbol = in_ch.node_symbol;
    req.wr_node.left   = in_ch.left_child;
    req.wr_node.right  = in_ch.right_child;
    req.rd_en         = 1'b0;
    req.rd_addr_a     = root_r;
    req.rd_addr_b     = ptr_r;
    emit              = 1'b0;
    emit_sym          = rsp.node_b.symbol;
    unique case (state_r)
      hf_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        req.wr_en   = in_acc && op == hf_pkg::OP_LOAD;
        req.rd_en   = in_acc && op == hf_pkg::OP_DECODE;
      end
      hf_pkg::ST_LOOK: begin
        req.rd_en     = !rsp.node_a.leaf;
        req.rd_addr_b = child_idx;
        emit          = rsp.node_a.leaf && out_free;
        emit_sym      = rsp.node_a.symbol;
      end
      hf_pkg::ST_CHILD: begin
        emit = rsp.node_b.leaf && out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (in_acc && op == hf_pkg::OP_RESTART) ptr_nxt = root_r;
    else if (state_r == hf_pkg::ST_CHILD) begin
      if (!rsp.node_b.leaf) ptr_nxt = child_r;
      else if (out_free)    ptr_nxt = root_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hf_pkg::ST_IDLE;
      root_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) root_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) bit_r <= in_ch.bit_value;
    if (state_r == hf_pkg::ST_LOOK) child_r <= child_idx;
    if (emit) out_sym_r <= emit_sym;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_sym_r;

  // a decode item always moves on to the root/pointer lookup
  a_decode_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op == hf_pkg::OP_DECODE |=> state_r == hf_pkg::ST_LOOK)
    else $error("decode item did not start a lookup");

  // a load never shares a cycle with a table read
  a_wr_rd_apart: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> !req.rd_en && state_r == hf_pkg::ST_IDLE)
    else $error("table write overlaps a read");

  // the child step only follows a lookup or a stalled child step
  a_child_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hf_pkg::ST_CHILD |->
      $past(state_r) == hf_pkg::ST_LOOK || $past(state_r) == hf_pkg::ST_CHILD)
    else $error("child step without lookup");

  // the pointer holds while the lookup is in flight
  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hf_pkg::ST_LOOK |=> $stable(ptr_r))
    else $error("walk pointer moved during lookup");

  // no result is dropped: an emit never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_sym_r))
    else $error("waiting result overwritten");

endmodule

FILE: rtl/core/huffman_tree_bit_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// load, restart and no-op items are done once accepted; a decode item reads
// root and walk pointer and, unless the root is a leaf, then the dependent
// child read, and its symbol waits while the result register is still full
// a symbol turns valid on out_ch once the lookup or child step registers it
// synchronous active-low reset clears root, walk pointer and result valid;
// the node table is not cleared and reads as undefined until loaded
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder #(
  parameter int NODE_SLOTS = hf_pkg::NODE_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  hf_in_if.sink                    in_ch,
  hf_out_if.source                 out_ch,
  input  logic                     cfg_wr_en,
  input  logic [hf_pkg::IDX_W-1:0] cfg_wr_data
);

  // table access between the sequencer and the node memory
  hf_pkg::mem_req_t req;
  hf_pkg::mem_rsp_t rsp;

  // sequencer: takes items, owns root and walk pointer, holds the result
  // register so a finished symbol can wait while the next item is taken
  hf_walk_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  // node table: port a serves the root, port b the pointer or the child;
  // slots at or beyond NODE_SLOTS read as zero and ignore writes
  hf_node_mem #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule
